>>> hdl/rvex_pkg.sv
// Shared constants, operation and status codes and payload types of the
// RV32IM execute unit. Depends on nothing.
`default_nettype none
package rvex_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NREGS     = 32;
  localparam int unsigned RF_AW     = $clog2(NREGS);
  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE     = 2'd1;

  localparam logic [5:0] OP_ADD = 6'd0,  OP_SUB = 6'd1,  OP_AND = 6'd2,  OP_OR = 6'd3;
  localparam logic [5:0] OP_XOR = 6'd4,  OP_SLT = 6'd5,  OP_SLTU = 6'd6, OP_SLL = 6'd7;
  localparam logic [5:0] OP_SRL = 6'd8,  OP_SRA = 6'd9,  OP_MUL = 6'd10, OP_MULH = 6'd11;
  localparam logic [5:0] OP_MULH_UU = 6'd12, OP_MULH_SU = 6'd13, OP_DIV = 6'd14;
  localparam logic [5:0] OP_DIVU = 6'd15, OP_REM = 6'd16, OP_REMU = 6'd17;
  localparam logic [5:0] OP_ADDI = 6'd18, OP_ANDI = 6'd19, OP_ORI = 6'd20, OP_XORI = 6'd21;
  localparam logic [5:0] OP_SLTI = 6'd22, OP_SLTI_U = 6'd23, OP_SLLI = 6'd24;
  localparam logic [5:0] OP_SRLI = 6'd25, OP_SRAI = 6'd26;
  localparam logic [5:0] OP_LB = 6'd27, OP_LH = 6'd28, OP_LW = 6'd29, OP_LBU = 6'd30;
  localparam logic [5:0] OP_LHU = 6'd31, OP_SB = 6'd32, OP_SH = 6'd33, OP_SW = 6'd34;
  localparam logic [5:0] OP_BEQ = 6'd35, OP_BNE = 6'd36, OP_BLT = 6'd37, OP_BGE = 6'd38;
  localparam logic [5:0] OP_BLTU = 6'd39, OP_BGEU = 6'd40, OP_JAL = 6'd41, OP_JALR = 6'd42;
  localparam logic [5:0] OP_LUI = 6'd43, OP_PC_UPPER = 6'd44, OP_ENV_CALL = 6'd45;
  localparam logic [5:0] OP_ENV_BREAK = 6'd46;

  localparam logic [2:0] ST_OK = 3'd0, ST_TAKEN = 3'd1, ST_ECALL = 3'd2, ST_EBREAK = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4, ST_RFAULT = 3'd5, ST_WFAULT = 3'd6;

  typedef struct packed {
    logic [5:0]        op;
    logic [4:0]        dest_reg;
    logic [4:0]        src_reg_a;
    logic [4:0]        src_reg_b;
    logic signed [31:0] immediate;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [31:0] written_value;
  } out_t;

endpackage
`default_nettype wire

>>> hdl/rvex_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module rvex_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/rv32im_execute_unit.sv
// Top level of the RV32IM execute unit: sequencer, ALU, multiplier, divider.
// Depends on rvex_pkg and rvex_ram.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_data_i (rvex_pkg::in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (rvex_pkg::out_t)
//   cfg     | input     | cfg_we_i              | cfg_addr_i, cfg_wdata_i
//
// After reset every byte of the data memory is swept to zero; no instruction is taken
// meanwhile, configuration writes are. An instruction reads its operands (S_RDA, S_RDB),
// executes (S_EXEC), then passes S_MUL for multiplies, S_DIV and S_DEND for divide and
// remainder, S_MEM for accesses that do not fault (one byte a cycle, loads also awaiting
// the registered read), and ends in S_FIN. The next transfer in can be taken in the cycle
// the result appears; a stalled result holds the block only once the next one is ready.
`default_nettype none
module rv32im_execute_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire rvex_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output rvex_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rvex_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [31:0]                     cfg_wdata_i
);
  import rvex_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RDA   = 10'b0000000100,
    S_RDB   = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_DEND  = 10'b0010000000,
    S_MEM   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  in_t                item_q;
  logic [31:0]        a_q, b_q, val_q, npc_q, pc_q, start_q, dbase_q;
  logic [2:0]         status_q;
  logic               wr_q;
  logic [NREGS-1:0]   rf_valid_q;
  logic               rf_rvalid_q;
  out_t               out_q;
  logic               out_valid_q;
  logic [4:0]         cnt_q;
  logic [MEM_AW-1:0]  off_q, clr_q;
  logic [31:0]        quo_q, rem_q, dvs_q;
  logic [63:0]        prod_q;

  // Register file port.
  logic [RF_AW-1:0]   rf_raddr;
  logic [31:0]        rf_rdata, rf_val;
  logic               rf_we;
  // Data memory port.
  logic               dm_we;
  logic [MEM_AW-1:0]  dm_waddr, dm_addr;
  logic [7:0]         dm_wdata, dm_rdata;

  logic               fin_go, fin_wr;
  logic [31:0]        fin_val;
  logic [2:0]         mem_n;

  rvex_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(item_q.dest_reg),
    .wdata_i(fin_val),
    .raddr_i(rf_raddr),
    .rdata_o(rf_rdata)
  );

  rvex_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk_i  (clk_i),
    .we_i   (dm_we),
    .waddr_i(dm_waddr),
    .wdata_i(dm_wdata),
    .raddr_i(dm_addr),
    .rdata_o(dm_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Registers never written read as zero, which also keeps x0 at zero.
  assign rf_raddr = (state_q == S_IDLE) ? in_data_i.src_reg_a : item_q.src_reg_b;
  assign rf_val   = rf_rvalid_q ? rf_rdata : 32'd0;

  always_comb begin
    unique case (item_q.op)
      OP_LH, OP_LHU, OP_SH: mem_n = 3'd2;
      OP_LW, OP_SW:         mem_n = 3'd4;
      default:              mem_n = 3'd1;
    endcase
  end

  assign dm_addr  = off_q + MEM_AW'(cnt_q);
  assign dm_we    = (state_q == S_CLEAR) || ((state_q == S_MEM) && (item_q.op >= OP_SB));
  assign dm_waddr = (state_q == S_CLEAR) ? clr_q : dm_addr;
  assign dm_wdata = (state_q == S_CLEAR) ? 8'd0 : b_q[{cnt_q[1:0], 3'b000} +: 8];

  // Write-back of the finishing instruction.
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign fin_wr = wr_q && (item_q.dest_reg != '0) &&
                  ((status_q == ST_OK) || (status_q == ST_TAKEN));
  always_comb begin
    fin_val = val_q;
    if (item_q.op == OP_LB) begin
      fin_val = {{24{val_q[7]}}, val_q[7:0]};
    end else if (item_q.op == OP_LH) begin
      fin_val = {{16{val_q[15]}}, val_q[15:0]};
    end
    if (!fin_wr) begin
      fin_val = 32'd0;
    end
  end
  assign rf_we = fin_go && fin_wr;

  // Execute stage values.
  logic [31:0]        y, sum, eaddr, moff, alu_val;
  logic [4:0]         shamt;
  logic               slt_y, sltu_y, slt_b, sltu_b, take, mem_ok;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               dsgn, a_neg, y_neg;

  assign y      = (item_q.op <= OP_REMU) ? b_q : 32'(item_q.immediate);
  assign sum    = a_q + y;
  assign shamt  = y[4:0];
  assign slt_y  = $signed(a_q) < $signed(y);
  assign sltu_y = a_q < y;
  assign slt_b  = $signed(a_q) < $signed(b_q);
  assign sltu_b = a_q < b_q;
  assign eaddr  = a_q + 32'(item_q.immediate);
  assign moff   = eaddr - dbase_q;
  assign mem_ok = moff <= (32'(MEM_BYTES) - 32'(mem_n));

  always_comb begin
    unique case (item_q.op)
      OP_SUB:                alu_val = a_q - y;
      OP_AND, OP_ANDI:       alu_val = a_q & y;
      OP_OR, OP_ORI:         alu_val = a_q | y;
      OP_XOR, OP_XORI:       alu_val = a_q ^ y;
      OP_SLT, OP_SLTI:       alu_val = {31'd0, slt_y};
      OP_SLTU, OP_SLTI_U:    alu_val = {31'd0, sltu_y};
      OP_SLL, OP_SLLI:       alu_val = a_q << shamt;
      OP_SRL, OP_SRLI:       alu_val = a_q >> shamt;
      OP_SRA, OP_SRAI:       alu_val = 32'($signed(a_q) >>> shamt);
      default:               alu_val = sum;
    endcase
  end

  always_comb begin
    unique case (item_q.op)
      OP_BEQ:  take = (a_q == b_q);
      OP_BNE:  take = (a_q != b_q);
      OP_BLT:  take = slt_b;
      OP_BGE:  take = !slt_b;
      OP_BLTU: take = sltu_b;
      default: take = !sltu_b;
    endcase
  end

  assign mul_a = {((item_q.op == OP_MULH) || (item_q.op == OP_MULH_SU)) & a_q[31], a_q};
  assign mul_b = {(item_q.op == OP_MULH) & b_q[31], b_q};
  assign mul_p = mul_a * mul_b;

  assign dsgn  = (item_q.op == OP_DIV) || (item_q.op == OP_REM);
  assign a_neg = dsgn & a_q[31];
  assign y_neg = dsgn & b_q[31];

  // One restoring division step.
  logic [32:0] rem_sh, dsub;
  assign rem_sh = {rem_q, quo_q[31]};
  assign dsub   = rem_sh - {1'b0, dvs_q};

  // End of division: RISC-V special results and sign fix-up.
  logic        is_div, dv_zero, dv_ovf;
  logic [31:0] dend_val;
  assign is_div  = (item_q.op == OP_DIV) || (item_q.op == OP_DIVU);
  assign dv_zero = (b_q == 32'd0);
  assign dv_ovf  = dsgn && (a_q == 32'h8000_0000) && (b_q == 32'hFFFF_FFFF);
  always_comb begin
    if (dv_zero) begin
      dend_val = is_div ? 32'hFFFF_FFFF : a_q;
    end else if (dv_ovf) begin
      dend_val = is_div ? a_q : 32'd0;
    end else if (is_div) begin
      dend_val = (a_neg ^ y_neg) ? (32'd0 - quo_q) : quo_q;
    end else begin
      dend_val = a_neg ? (32'd0 - rem_q) : rem_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_RDA;
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_EXEC;
      S_EXEC: begin
        if ((item_q.op >= OP_MUL) && (item_q.op <= OP_MULH_SU)) begin
          state_d = S_MUL;
        end else if ((item_q.op >= OP_DIV) && (item_q.op <= OP_REMU)) begin
          state_d = S_DIV;
        end else if ((item_q.op >= OP_LB) && (item_q.op <= OP_SW) && mem_ok) begin
          state_d = S_MEM;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL:   state_d = S_FIN;
      S_DIV:   if (cnt_q == '1) state_d = S_DEND;
      S_DEND:  state_d = S_FIN;
      S_MEM: begin
        if (item_q.op >= OP_SB) begin
          if (cnt_q == 5'({2'b00, mem_n} - 5'd1)) state_d = S_FIN;
        end else if (cnt_q == {2'b00, mem_n}) begin
          state_d = S_FIN;
        end
      end
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= '0;
      pc_q        <= 32'd0;
      start_q     <= 32'd0;
      dbase_q     <= 32'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + MEM_AW'(1);
        // The first cycle out of reset loads the start address.
        if (clr_q == '0) pc_q <= start_q;
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_START_ADDRESS) start_q <= cfg_wdata_i;
        if (cfg_addr_i == CFG_DATA_BASE) dbase_q <= cfg_wdata_i;
      end
      if ((state_q == S_EXEC) || (state_q == S_FIN)) begin
        cnt_q <= '0;
      end else if ((state_q == S_DIV) || (state_q == S_MEM)) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
        pc_q        <= npc_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) rf_valid_q[item_q.dest_reg] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rf_rvalid_q <= rf_valid_q[rf_raddr];
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
    if (state_q == S_RDA) a_q <= rf_val;
    if (state_q == S_RDB) b_q <= rf_val;
    if (state_q == S_EXEC) begin
      status_q <= ST_OK;
      npc_q    <= pc_q + 32'd4;
      wr_q     <= 1'b0;
      val_q    <= 32'd0;
      off_q    <= moff[MEM_AW-1:0];
      prod_q   <= mul_p[63:0];
      quo_q    <= a_neg ? (32'd0 - a_q) : a_q;
      dvs_q    <= y_neg ? (32'd0 - b_q) : b_q;
      rem_q    <= 32'd0;
      if (item_q.op <= OP_SRAI) begin
        wr_q  <= 1'b1;
        val_q <= alu_val;
      end else if (item_q.op <= OP_LHU) begin
        wr_q <= 1'b1;
        if (!mem_ok) begin
          status_q <= ST_RFAULT;
          npc_q    <= pc_q;
        end
      end else if (item_q.op <= OP_SW) begin
        if (!mem_ok) begin
          status_q <= ST_WFAULT;
          npc_q    <= pc_q;
        end
      end else if (item_q.op <= OP_BGEU) begin
        if (take) begin
          status_q <= ST_TAKEN;
          npc_q    <= pc_q + 32'(item_q.immediate);
        end
      end else if (item_q.op == OP_JAL) begin
        status_q <= ST_TAKEN;
        wr_q     <= 1'b1;
        val_q    <= pc_q + 32'd4;
        npc_q    <= pc_q + 32'(item_q.immediate);
      end else if (item_q.op == OP_JALR) begin
        status_q <= ST_TAKEN;
        wr_q     <= 1'b1;
        val_q    <= pc_q + 32'd4;
        npc_q    <= {eaddr[31:1], 1'b0};
      end else if (item_q.op == OP_LUI) begin
        wr_q  <= 1'b1;
        val_q <= 32'(item_q.immediate);
      end else if (item_q.op == OP_PC_UPPER) begin
        wr_q  <= 1'b1;
        val_q <= pc_q + 32'(item_q.immediate);
      end else begin
        npc_q <= pc_q;
        if (item_q.op == OP_ENV_CALL) begin
          status_q <= ST_ECALL;
        end else if (item_q.op == OP_ENV_BREAK) begin
          status_q <= ST_EBREAK;
        end else begin
          status_q <= ST_INVALID;
        end
      end
    end
    if (state_q == S_MUL) begin
      val_q <= (item_q.op == OP_MUL) ? prod_q[31:0] : prod_q[63:32];
    end
    if (state_q == S_DIV) begin
      rem_q <= dsub[32] ? rem_sh[31:0] : dsub[31:0];
      quo_q <= {quo_q[30:0], !dsub[32]};
    end
    if (state_q == S_DEND) val_q <= dend_val;
    // Load bytes arrive in the cycle after their address.
    if ((state_q == S_MEM) && (cnt_q != '0) && (item_q.op < OP_SB)) begin
      val_q[{cnt_q[1:0] - 2'd1, 3'b000} +: 8] <= dm_rdata;
    end
    if (fin_go) begin
      out_q.status        <= status_q;
      out_q.next_pc       <= npc_q;
      out_q.reg_written   <= fin_wr;
      out_q.written_value <= fin_val;
    end
  end

`ifndef NO_ASSERTIONS
  a_x0_never_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_valid_q[0]) else $error("register x0 marked as written");
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RDA))
    else $error("accepted instruction did not start its operand reads");
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result presented outside write-back");
  a_dmem_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_we |-> ((state_q == S_CLEAR) || (state_q == S_MEM)))
    else $error("data memory written outside clear or store");
`endif

endmodule
`default_nettype wire
